[sv/dvrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int unsigned NODES_DEF = 16;
  localparam logic [15:0] INF_COST  = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_ADVERT  = 3'd1,
    CMD_SETCOST = 3'd2,
    CMD_DISABLE = 3'd3,
    CMD_PROBE   = 3'd4,
    CMD_CRASH   = 3'd5,
    CMD_READ    = 3'd6,
    CMD_BAD     = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_INVALID = 3'd1,
    ST_NOT_NB  = 3'd2,
    ST_SAME    = 3'd3,
    ST_CRASHED = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD1   = 5'b00010,
    S_EXEC  = 5'b00100,
    S_WIPE  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

endpackage

[sv/distance_vector_route_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Route cost and neighbor liveness table driven by one command per transaction.
// ----------------------------------------------------------------------------
// Each transaction takes one command and returns one result. The cost table
// lives in a memory with one read and one write port, so a command reads its
// entries one per cycle: an ordinary command reads the node, reads the sender
// and updates, and offers its result in S_OUT; the next command is taken in
// the cycle after the result leaves. A crash sweeps the table in S_WIPE, one
// entry a cycle. A result stall holds the block in S_OUT. Liveness counters
// are flip-flops cleared at reset; the cost memory reads as infinity until
// an entry is written, tracked by one valid bit per entry. The input is not
// taken while a command runs.
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_self_index,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_sender,
  input  logic [3:0]  in_node,
  input  logic [15:0] in_metric,
  input  logic        in_ack,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_node_cost,
  output logic [1:0]  out_node_liveness,
  output logic [4:0]  out_link_count
);

  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned LW = $clog2(NODES + 1);

  state_t state_r, state_nxt;

  logic [3:0]    self_r;
  logic [15:0]   mem [NODES];
  logic [NODES-1:0] vld_r;
  logic [1:0]    live_r [NODES];
  logic [LW-1:0] links_r;
  logic          crashed_r;

  logic [2:0]  cmd_r;
  logic [3:0]  snd_r, nd_r;
  logic [15:0] m_r;
  logic        ack_r;
  logic [15:0] rd_r, c_r;
  logic [IW-1:0] rd_addr;
  logic        rd_vld_r;
  logic [IW-1:0] wipe_r;

  // Config is taken only while idle
  assign cfg_ready = state_r == S_IDLE;
  assign in_stall  = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) self_r <= 4'd0;
    else if (cfg_valid && cfg_ready) self_r <= cfg_self_index;
  end

  // Argument decode
  logic nd_ok, snd_ok, nd_self, snd_self;
  logic [IW-1:0] nd_i, snd_i;
  assign nd_ok    = {28'd0, nd_r} < NODES;
  assign snd_ok   = {28'd0, snd_r} < NODES;
  assign nd_self  = nd_r == self_r;
  assign snd_self = snd_r == self_r;
  assign nd_i     = IW'(nd_r);
  assign snd_i    = IW'(snd_r);

  // Memory read: node in S_RD1 cycle, sender in S_EXEC cycle prep
  assign rd_addr = (state_r == S_IDLE) ? IW'(in_node) : snd_i;
  always_ff @(posedge clk) begin
    rd_r     <= mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end
  logic [15:0] rd_cost;
  assign rd_cost = rd_vld_r ? rd_r : INF_COST;

  // Input capture
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_command;
      snd_r <= in_sender;
      nd_r  <= in_node;
      m_r   <= in_metric;
      ack_r <= in_ack;
    end
    if (state_r == S_RD1) c_r <= rd_cost;
  end

  // Shared update unit
  logic [16:0]   sum;
  logic [15:0]   s_sat;
  logic [15:0]   cs;
  logic [1:0]    ln, ls;
  logic          we;
  logic [IW-1:0] wa;
  logic [15:0]   wd;
  logic [1:0]    lnd_nxt, lsnd_nxt;
  logic          wr_lnd, wr_lsnd;
  logic          up, down, chg, up_snd;
  status_t       st;

  assign cs    = rd_cost;
  assign sum   = {1'b0, cs} + {1'b0, m_r};
  assign s_sat = sum[16] ? INF_COST : sum[15:0];
  assign ln    = nd_ok ? live_r[nd_i] : 2'd0;
  assign ls    = snd_ok ? live_r[snd_i] : 2'd0;

  always_comb begin
    we = 1'b0; wa = nd_i; wd = m_r;
    wr_lnd = 1'b0; lnd_nxt = ln;
    wr_lsnd = 1'b0; lsnd_nxt = 2'd1;
    up = 1'b0; down = 1'b0; chg = 1'b0; up_snd = 1'b0;
    st = ST_DONE;
    if (crashed_r && cmd_r != CMD_READ && cmd_r != CMD_BAD) begin
      st = ST_CRASHED;
    end else begin
      unique case (cmd_t'(cmd_r))
        CMD_LOAD: begin
          if (!nd_ok || nd_self || m_r == 16'd0 || m_r == INF_COST) st = ST_INVALID;
          else begin
            up = ln == 2'd0; wr_lnd = 1'b1; lnd_nxt = 2'd1; we = 1'b1;
          end
        end
        CMD_ADVERT: begin
          if (!snd_ok || snd_self || !nd_ok) st = ST_INVALID;
          else begin
            // sender link counts first, then any change for the node
            wr_lsnd = 1'b1;
            if (ls == 2'd0) begin up_snd = 1'b1; chg = 1'b1; end
            if (ls != 2'd1) chg = 1'b1;
            if (m_r != 16'd0) begin
              if (nd_self) begin
                if (cs != m_r) begin we = 1'b1; wa = snd_i; wd = m_r; chg = 1'b1; end
              end else if (c_r == INF_COST && m_r != INF_COST) begin
                if (ln == 2'd0 && !(nd_r == snd_r)) begin
                  we = 1'b1; wd = s_sat; up = 1'b1; chg = 1'b1;
                end
              end else if (c_r != INF_COST && m_r == INF_COST) begin
                if (ln == 2'd0 && !(nd_r == snd_r)) begin
                  we = 1'b1; wd = INF_COST; down = 1'b1; chg = 1'b1;
                end
              end else if (c_r != INF_COST && m_r != INF_COST) begin
                if ((ln == 2'd0 && !(nd_r == snd_r)) || c_r > s_sat) begin
                  if (c_r != s_sat) begin we = 1'b1; wd = s_sat; chg = 1'b1; end
                end
              end
            end
            st = chg ? ST_DONE : ST_SAME;
          end
        end
        CMD_SETCOST: begin
          if (!nd_ok || nd_self || m_r == 16'd0) st = ST_INVALID;
          else if (ln == 2'd0) st = ST_NOT_NB;
          else if (c_r == m_r) st = ST_SAME;
          else begin
            we = 1'b1;
            if (m_r == INF_COST) begin down = 1'b1; wr_lnd = 1'b1; lnd_nxt = 2'd0; end
          end
        end
        CMD_DISABLE: begin
          if (!nd_ok || nd_self) st = ST_INVALID;
          else if (ln == 2'd0) st = ST_NOT_NB;
          else if (c_r == INF_COST) st = ST_SAME;
          else begin
            we = 1'b1; wd = INF_COST; down = 1'b1; wr_lnd = 1'b1; lnd_nxt = 2'd0;
          end
        end
        CMD_PROBE: begin
          if (!nd_ok) st = ST_INVALID;
          else if (ln == 2'd0) st = ST_NOT_NB;
          else if (ack_r) begin wr_lnd = 1'b1; lnd_nxt = 2'd1; end
          else if (ln == 2'd3) begin
            we = 1'b1; wd = INF_COST; down = 1'b1; wr_lnd = 1'b1; lnd_nxt = 2'd0;
          end else begin wr_lnd = 1'b1; lnd_nxt = ln + 2'd1; end
        end
        CMD_CRASH: st = ST_DONE;
        CMD_READ:  st = nd_ok ? ST_DONE : ST_INVALID;
        default:   st = ST_INVALID;
      endcase
    end
  end

  // Link count: sender step, then node step, each saturating
  logic [LW-1:0] links_mid, links_nxt;
  always_comb begin
    links_mid = links_r;
    if (up_snd && {{(32-LW){1'b0}}, links_r} < NODES) links_mid = links_r + LW'(1);
    links_nxt = links_mid;
    if (up && {{(32-LW){1'b0}}, links_mid} < NODES) links_nxt = links_mid + LW'(1);
    else if (down && links_mid != '0) links_nxt = links_mid - LW'(1);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD1;
      S_RD1:  state_nxt = S_EXEC;
      S_EXEC: state_nxt = (cmd_r == CMD_CRASH && !crashed_r) ? S_WIPE : S_OUT;
      S_WIPE: if ({{(32-IW){1'b0}}, wipe_r} == NODES - 1) state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Cost memory write port
  logic          mwe;
  logic [IW-1:0] mwa;
  logic [15:0]   mwd;
  always_comb begin
    mwe = (state_r == S_EXEC) && we;
    mwa = wa;
    mwd = wd;
    if (state_r == S_WIPE) begin mwe = 1'b1; mwa = wipe_r; mwd = INF_COST; end
  end
  always_ff @(posedge clk) begin
    if (mwe) mem[mwa] <= mwd;
  end

  // Table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      links_r   <= '0;
      crashed_r <= 1'b0;
      wipe_r    <= '0;
      for (int i = 0; i < NODES; i++) live_r[i] <= 2'd0;
    end else begin
      if (mwe) vld_r[mwa] <= 1'b1;
      if (state_r == S_EXEC) begin
        wipe_r <= '0;
        if (wr_lsnd) live_r[snd_i] <= lsnd_nxt;
        if (wr_lnd)  live_r[nd_i]  <= lnd_nxt;
        links_r <= links_nxt;
        if (cmd_r == CMD_CRASH && !crashed_r) begin
          crashed_r <= 1'b1;
          links_r   <= '0;
          for (int i = 0; i < NODES; i++) live_r[i] <= 2'd0;
        end
      end
      if (state_r == S_WIPE) wipe_r <= wipe_r + 1'b1;
    end
  end

  // Result register; node cost comes from the write data when the node entry is written, else from the earlier read
  logic [2:0] st_r;
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) st_r <= st;
  end

  logic [15:0] out_c_r;
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      if (mwe && mwa == nd_i) out_c_r <= mwd;
      else if (nd_self && cmd_r == CMD_ADVERT) out_c_r <= c_r;
      else out_c_r <= c_r;
    end else if (state_r == S_WIPE) out_c_r <= INF_COST;
  end

  assign out_valid         = state_r == S_OUT;
  assign out_status        = st_r;
  assign out_node_cost     = nd_ok ? out_c_r : INF_COST;
  assign out_node_liveness = nd_ok ? live_r[nd_i] : 2'd0;
  assign out_link_count    = 5'(links_r);

  // Checks
  a_link_max: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-LW){1'b0}}, links_r} <= NODES) else $error("link count over limit");
  a_crash_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (crashed_r && state_r == S_IDLE) |-> links_r == '0) else $error("links after crash");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table testbench
// Drives command transactions into the route table with random idle and
// stall cycles, predicts every result in an internal table model and checks
// each returned result field by field. The router index is moved between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import dvrt_pkg::*;

  localparam int NUM_NODES = 16;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  sender;
    logic [3:0]  node;
    logic [15:0] metric;
    logic        ack;
  } route_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] cost;
    logic [1:0]  liveness;
    logic [4:0]  links;
  } route_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_self_index = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = '0;
  logic [3:0]  in_sender = '0;
  logic [3:0]  in_node = '0;
  logic [15:0] in_metric = '0;
  logic        in_ack = 1'b0;
  logic        out_stall = 1'b0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_node_cost;
  logic [1:0]  out_node_liveness;
  logic [4:0]  out_link_count;

  distance_vector_route_table dut (.*);

  always #2 clk = ~clk;

  // Predictor state
  logic [15:0] cost_q [NUM_NODES];
  logic [1:0]  live_q [NUM_NODES];
  int          link_cnt;
  bit          is_crashed;
  logic [3:0]  self_id;

  route_cmd_t    pending_cmds[$];
  route_result_t expected_results[$];
  int  error_cnt;
  int  result_cnt;
  int  cmd_cnt;
  bit  calm;         // no idling while set

  function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > 17'hFFFF) ? INF_COST : s[15:0];
  endfunction

  function automatic void links_inc();
    if (link_cnt < NUM_NODES) link_cnt++;
  endfunction

  function automatic void links_dec();
    if (link_cnt > 0) link_cnt--;
  endfunction

  function automatic route_result_t route_predict(route_cmd_t c);
    route_result_t r;
    status_t st;
    int n, s;
    bit is_self, chg, nb;
    logic [15:0] cur, sum, m;
    n = c.node;
    s = c.sender;
    m = c.metric;
    is_self = (c.node == self_id);
    st = ST_DONE;
    if (is_crashed && c.command <= CMD_CRASH) begin
      st = ST_CRASHED;
    end else begin
      case (c.command)
        CMD_LOAD: begin
          if (is_self || m == 0 || m == INF_COST) st = ST_INVALID;
          else begin
            if (live_q[n] == 0) links_inc();
            live_q[n] = 1;
            cost_q[n] = m;
          end
        end
        CMD_ADVERT: begin
          if (c.sender == self_id) st = ST_INVALID;
          else begin
            chg = 0;
            if (live_q[s] == 0) begin
              links_inc();
              chg = 1;
            end
            if (live_q[s] != 1) begin
              live_q[s] = 1;
              chg = 1;
            end
            if (m != 0) begin
              cur = cost_q[n];
              sum = sat_sum(cost_q[s], m);
              nb = live_q[n] != 0;
              if (is_self) begin
                if (cost_q[s] != m) begin
                  cost_q[s] = m;
                  chg = 1;
                end
              end else if (cur == INF_COST && m < INF_COST) begin
                if (!nb) begin
                  cost_q[n] = sum;
                  links_inc();
                  chg = 1;
                end
              end else if (cur < INF_COST && m == INF_COST) begin
                if (!nb) begin
                  cost_q[n] = INF_COST;
                  links_dec();
                  chg = 1;
                end
              end else if (cur < INF_COST && m < INF_COST) begin
                if ((!nb || cur > sum) && cost_q[n] != sum) begin
                  cost_q[n] = sum;
                  chg = 1;
                end
              end
            end
            st = chg ? ST_DONE : ST_SAME;
          end
        end
        CMD_SETCOST: begin
          if (is_self || m == 0) st = ST_INVALID;
          else if (live_q[n] == 0) st = ST_NOT_NB;
          else if (cost_q[n] == m) st = ST_SAME;
          else begin
            cost_q[n] = m;
            if (m == INF_COST) begin
              links_dec();
              live_q[n] = 0;
            end
          end
        end
        CMD_DISABLE: begin
          if (is_self) st = ST_INVALID;
          else if (live_q[n] == 0) st = ST_NOT_NB;
          else if (cost_q[n] == INF_COST) st = ST_SAME;
          else begin
            cost_q[n] = INF_COST;
            live_q[n] = 0;
            links_dec();
          end
        end
        CMD_PROBE: begin
          if (live_q[n] == 0) st = ST_NOT_NB;
          else if (c.ack) live_q[n] = 1;
          else if (live_q[n] == 3) begin
            cost_q[n] = INF_COST;
            live_q[n] = 0;
            links_dec();
          end else live_q[n] = live_q[n] + 1;
        end
        CMD_CRASH: begin
          foreach (cost_q[i]) begin
            cost_q[i] = INF_COST;
            live_q[i] = 0;
          end
          link_cnt = 0;
          is_crashed = 1;
        end
        CMD_READ: st = ST_DONE;
        default: st = ST_INVALID;
      endcase
    end
    r.status = st;
    r.cost = cost_q[n];
    r.liveness = live_q[n];
    r.links = link_cnt[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0h expected %0h", result_cnt, what, got, want);
    error_cnt++;
  endtask

  // Driver: presents queued commands and predicts each accepted one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(route_predict(pending_cmds.pop_front()));
        cmd_cnt++;
      end
      if ((!in_valid || !in_stall) && pending_cmds.size() > 0
          && (calm || $urandom_range(99) >= 38)) begin
        in_valid   <= 1'b1;
        in_command <= pending_cmds[0].command;
        in_sender  <= pending_cmds[0].sender;
        in_node    <= pending_cmds[0].node;
        in_metric  <= pending_cmds[0].metric;
        in_ack     <= pending_cmds[0].ack;
      end else if (!in_valid || !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and result check
  always @(posedge clk) begin
    route_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_status, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_node_cost !== want.cost) report_mismatch("cost", out_node_cost, want.cost);
          if (out_node_liveness !== want.liveness)
            report_mismatch("liveness", out_node_liveness, want.liveness);
          if (out_link_count !== want.links)
            report_mismatch("link count", out_link_count, want.links);
        end
        result_cnt++;
      end
      out_stall <= !calm && ($urandom_range(99) < 38);
    end
  end

  function automatic route_cmd_t mk(cmd_t c, int s, int n, int m, bit a);
    route_cmd_t r;
    r.command = c;
    r.sender = s[3:0];
    r.node = n[3:0];
    r.metric = m[15:0];
    r.ack = a;
    return r;
  endfunction

  // Mostly valid commands over all sixteen nodes, some noise
  function automatic route_cmd_t rand_cmd();
    int k, m;
    cmd_t c;
    k = $urandom_range(99);
    if (k < 18) c = CMD_LOAD;
    else if (k < 50) c = CMD_ADVERT;
    else if (k < 60) c = CMD_SETCOST;
    else if (k < 67) c = CMD_DISABLE;
    else if (k < 84) c = CMD_PROBE;
    else if (k < 97) c = CMD_READ;
    else c = CMD_BAD;
    case ($urandom_range(9))
      0: m = 0;
      1: m = 16'hFFFF;
      2: m = 16'hFFFE;
      3: m = $urandom_range(16'hFFFF);
      default: m = $urandom_range(1, 200);
    endcase
    return mk(c, $urandom_range(15), $urandom_range(15), m, $urandom_range(1));
  endfunction

  task automatic write_self(int v);
    cfg_self_index <= v[3:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    self_id = v[3:0];
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int selves[4];
    selves = '{0, 15, 7, 3};
    foreach (cost_q[i]) begin
      cost_q[i] = INF_COST;
      live_q[i] = 0;
    end
    link_cnt = 0;
    is_crashed = 0;
    self_id = 0;
    error_cnt = 0;
    result_cnt = 0;
    cmd_cnt = 0;
    calm = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_self(5);
    // Directed: each command but crash, field extremes, dead neighbor, saturation
    pending_cmds.push_back(mk(CMD_LOAD, 0, 5, 10, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 0, 2, 0, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 0, 2, 16'hFFFF, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 0, 2, 16'hFFFE, 1));
    pending_cmds.push_back(mk(CMD_ADVERT, 2, 9, 16'hFFFE, 1));
    pending_cmds.push_back(mk(CMD_ADVERT, 15, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ADVERT, 15, 5, 7, 0));
    pending_cmds.push_back(mk(CMD_ADVERT, 15, 9, 16'hFFFF, 0));
    pending_cmds.push_back(mk(CMD_ADVERT, 5, 9, 3, 0));
    pending_cmds.push_back(mk(CMD_SETCOST, 0, 2, 4, 0));
    pending_cmds.push_back(mk(CMD_SETCOST, 0, 2, 4, 0));
    pending_cmds.push_back(mk(CMD_SETCOST, 0, 11, 4, 0));
    pending_cmds.push_back(mk(CMD_SETCOST, 0, 2, 16'hFFFF, 0));
    pending_cmds.push_back(mk(CMD_DISABLE, 0, 15, 0, 0));
    pending_cmds.push_back(mk(CMD_DISABLE, 0, 15, 0, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 0, 1, 1, 0));
    for (int i = 0; i < 4; i++) pending_cmds.push_back(mk(CMD_PROBE, 0, 1, 0, 0));
    pending_cmds.push_back(mk(CMD_PROBE, 0, 0, 0, 1));
    pending_cmds.push_back(mk(CMD_BAD, 15, 15, 16'hFFFF, 1));
    pending_cmds.push_back(mk(CMD_READ, 0, 15, 0, 0));
    drain();
    // Random phases; the crash comes only at the end of the last phase
    for (int p = 0; p < 4; p++) begin
      calm = (p == 1);
      write_self(selves[p]);
      for (int i = 0; i < 150; i++) begin
        pending_cmds.push_back((i == 149 && p == 3) ? mk(CMD_CRASH, 0, 0, 0, 0) : rand_cmd());
      end
      pending_cmds.push_back(mk(CMD_READ, 0, $urandom_range(15), 0, 0));
      drain();
    end
    // After the crash: commands ignored, reads still served
    pending_cmds.push_back(mk(CMD_LOAD, 0, 3, 5, 0));
    pending_cmds.push_back(mk(CMD_CRASH, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 15, 0, 0));
    drain();
    $display("covered %0d commands and %0d results over 5 router index settings",
             cmd_cnt, result_cnt);
    if (error_cnt == 0 && expected_results.size() == 0) begin
      $display("[distance_vector_route_table] OK");
    end else begin
      $display("[distance_vector_route_table] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[distance_vector_route_table] ERROR");
    $finish;
  end

endmodule
